// File: rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// Binary insertion sorter package
// Sizes, widths and request/result types shared by the sorter RTL.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int CAPACITY     = 32;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 16;

    // Store address and fill count (count must reach CAPACITY itself).
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic [PAYLOAD_BITS-1:0]    payload;
        logic                       last;
    } in_req_t;

    typedef struct packed {
        logic signed [KEY_BITS-1:0] sorted_key;
        logic [PAYLOAD_BITS-1:0]    sorted_payload;
        logic                       final_res;
        logic                       overflowed;
    } out_res_t;

    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic [PAYLOAD_BITS-1:0]    payload;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PROBE = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

endpackage

// File: rtl/binary_insertion_sorter_top.sv
// ----------------------------------------------------------------------------
// Binary insertion sorter
// Stable sort of (key, payload) requests; the set is emitted in ascending key
// order on the request marked last.
// ----------------------------------------------------------------------------
//
//  channel | ports              | direction | contents
//  --------+--------------------+-----------+-----------------------------------
//  s_      | s_valid/s_ready    | in        | s_data: key, payload, last
//  m_      | m_valid/m_ready    | out       | m_data: sorted_key, sorted_payload,
//          |                    |           |         final_res, overflowed
//
//  Insert: accept, then one probe per search step (at most 5, as at most
//  31 entries are stored when a request is inserted), one shift per entry
//  moved up (fill - slot), then a write; the single store read port sets this.
//  Emit: first result valid after the store read and the output load, then one
//  per cycle while m_ready is high; m_ready low holds output and read.
//  s_ready is high only in idle. Reset clears sequencer, fill count, drop flag.
//
module binary_insertion_sorter_top
    import bis_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,

    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_data,

    output logic     m_valid,
    input  logic     m_ready,
    output out_res_t m_data
);

    // ------------------------------------------------------------------------
    // Record store: one write port, one registered read port
    // ------------------------------------------------------------------------
    entry_t             mem [CAPACITY];
    entry_t             rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    entry_t             wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------------
    state_t             state_reg,     state_next;
    logic [CNT_W-1:0]   fill_reg,      fill_next;
    logic               drop_reg,      drop_next;
    logic [CNT_W-1:0]   lo_reg,        lo_next;
    logic [CNT_W-1:0]   hi_reg,        hi_next;
    logic [CNT_W-1:0]   ptr_reg,       ptr_next;
    entry_t             new_reg,       new_next;
    logic               last_reg,      last_next;
    logic [CNT_W-1:0]   rd_idx_reg,    rd_idx_next;
    logic               pend_reg,      pend_next;
    logic               pend_last_reg, pend_last_next;
    logic               m_valid_reg,   m_valid_next;
    out_res_t           m_data_reg,    m_data_next;

    // Shared compare unit: one search step on the entry just read.
    logic               key_less;
    logic [CNT_W-1:0]   lo_step;
    logic [CNT_W-1:0]   hi_step;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid_step;
    logic [CNT_W-1:0]   mid_first;

    // Output side handshake terms.
    logic               out_take;
    logic               can_load;
    logic               do_load;
    logic               rd_more;

    assign key_less  = $signed(new_reg.key) < $signed(rd_data_reg.key);
    // Probe address sits in lo..hi; upper half drops when new key is smaller.
    assign hi_step   = key_less ? ptr_reg : hi_reg;
    assign lo_step   = key_less ? lo_reg : ptr_reg + CNT_W'(1);
    assign mid_sum   = {1'b0, lo_step} + {1'b0, hi_step};
    assign mid_step  = mid_sum[CNT_W:1];
    assign mid_first = {1'b0, fill_reg[CNT_W-1:1]};

    assign out_take  = m_valid_reg && m_ready;
    assign can_load  = !m_valid_reg || m_ready;
    assign do_load   = pend_reg && can_load;
    assign rd_more   = rd_idx_reg < fill_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ptr_next       = ptr_reg;
        new_next       = new_reg;
        last_next      = last_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = new_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    new_next.key     = s_data.key;
                    new_next.payload = s_data.payload;
                    last_next        = s_data.last;
                    rd_idx_next      = '0;
                    pend_next        = 1'b0;
                    if (fill_reg == CNT_W'(CAPACITY)) begin
                        // Store full: drop the request, emit if it closes the set.
                        drop_next  = 1'b1;
                        state_next = s_data.last ? ST_EMIT : ST_IDLE;
                    end else if (fill_reg == '0) begin
                        lo_next    = '0;
                        state_next = ST_WRITE;
                    end else begin
                        // First probe at the middle of 0..fill.
                        lo_next    = '0;
                        hi_next    = fill_reg;
                        ptr_next   = mid_first;
                        rd_en      = 1'b1;
                        rd_addr    = mid_first[ADDR_W-1:0];
                        state_next = ST_PROBE;
                    end
                end
            end

            ST_PROBE: begin
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step < hi_step) begin
                    ptr_next = mid_step;
                    rd_en    = 1'b1;
                    rd_addr  = mid_step[ADDR_W-1:0];
                end else if (fill_reg > lo_step) begin
                    // Slot found below the top: start moving entries up.
                    ptr_next   = fill_reg;
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(fill_reg - CNT_W'(1));
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_WRITE;
                end
            end

            ST_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg[ADDR_W-1:0];
                wr_data = rd_data_reg;
                if ((ptr_reg - CNT_W'(1)) > lo_reg) begin
                    ptr_next = ptr_reg - CNT_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = ADDR_W'(ptr_reg - CNT_W'(2));
                end else begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE: begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg[ADDR_W-1:0];
                wr_data    = new_reg;
                fill_next  = fill_reg + CNT_W'(1);
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end

            ST_EMIT: begin
                if (out_take && m_data_reg.final_res) begin
                    // Final result taken: empty the store for the next set.
                    m_valid_next = 1'b0;
                    pend_next    = 1'b0;
                    fill_next    = '0;
                    drop_next    = 1'b0;
                    state_next   = ST_IDLE;
                end else begin
                    if (do_load) begin
                        m_data_next.sorted_key     = rd_data_reg.key;
                        m_data_next.sorted_payload = rd_data_reg.payload;
                        m_data_next.final_res      = pend_last_reg;
                        m_data_next.overflowed     = drop_reg;
                        m_valid_next               = 1'b1;
                    end else if (out_take) begin
                        m_valid_next = 1'b0;
                    end
                    // Fetch the next entry once the read register is free.
                    if (rd_more && (!pend_reg || do_load)) begin
                        rd_en          = 1'b1;
                        rd_addr        = rd_idx_reg[ADDR_W-1:0];
                        rd_idx_next    = rd_idx_reg + CNT_W'(1);
                        pend_next      = 1'b1;
                        pend_last_next = (rd_idx_reg + CNT_W'(1)) == fill_reg;
                    end else if (do_load) begin
                        pend_next = 1'b0;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state: synchronous active low reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            drop_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            drop_reg    <= drop_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers: no reset needed.
    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        ptr_reg       <= ptr_next;
        new_reg       <= new_next;
        last_reg      <= last_next;
        rd_idx_reg    <= rd_idx_next;
        pend_last_reg <= pend_last_next;
        m_data_reg    <= m_data_next;
    end

endmodule

// File: tb/sort_order_checker.sv
// ----------------------------------------------------------------------------
// Sort order checker
// Watches both channels of the sorter, keeps a sorted shadow of its store and
// compares every emitted result with the predicted stable ascending order.
// ----------------------------------------------------------------------------
module sort_order_checker
    import bis_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  in_req_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  out_res_t m_data,
    output int       mismatch_count,
    output int       pending_results
);

    entry_t   shadow_store [CAPACITY];
    int       shadow_fill;
    logic     shadow_dropped;
    out_res_t sorted_results [$];
    int       mismatches;

    task automatic report_mismatch(input string msg);
        $display("[%0t] sorter mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, predicted %0h", field, got, want));
        end
    endtask

    always @(posedge aclk) begin : watch
        out_res_t want;
        int       lo;
        int       hi;
        int       mid;
        int       j;
        if (!aresetn) begin
            shadow_fill    = 0;
            shadow_dropped = 1'b0;
            mismatches     = 0;
            sorted_results.delete();
        end else begin
            // Check results before predicting: a request cannot produce a
            // result at its own acceptance edge.
            if (m_valid && m_ready) begin
                if (sorted_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result key %0d payload %0h",
                                              $signed(m_data.sorted_key),
                                              m_data.sorted_payload));
                end else begin
                    want = sorted_results.pop_front();
                    compare_field("sorted_key", 32'(m_data.sorted_key),
                                  32'(want.sorted_key));
                    compare_field("sorted_payload", 32'(m_data.sorted_payload),
                                  32'(want.sorted_payload));
                    compare_field("final_res", 32'(m_data.final_res),
                                  32'(want.final_res));
                    compare_field("overflowed", 32'(m_data.overflowed),
                                  32'(want.overflowed));
                end
            end
            if (s_valid && s_ready) begin
                if (shadow_fill < CAPACITY) begin
                    // Slot goes after every stored key not greater than the new one.
                    lo = 0;
                    hi = shadow_fill;
                    while (lo < hi) begin
                        mid = (lo + hi) / 2;
                        if ($signed(s_data.key) <
                            $signed(shadow_store[ADDR_W'(mid)].key)) begin
                            hi = mid;
                        end else begin
                            lo = mid + 1;
                        end
                    end
                    for (j = shadow_fill; j > lo; j--) begin
                        shadow_store[ADDR_W'(j)] = shadow_store[ADDR_W'(j-1)];
                    end
                    shadow_store[ADDR_W'(lo)].key     = s_data.key;
                    shadow_store[ADDR_W'(lo)].payload = s_data.payload;
                    shadow_fill++;
                end else begin
                    shadow_dropped = 1'b1;
                end
                if (s_data.last) begin
                    for (j = 0; j < shadow_fill; j++) begin
                        want.sorted_key     = shadow_store[ADDR_W'(j)].key;
                        want.sorted_payload = shadow_store[ADDR_W'(j)].payload;
                        want.final_res      = (j == shadow_fill - 1);
                        want.overflowed     = shadow_dropped;
                        sorted_results.push_back(want);
                    end
                    shadow_fill    = 0;
                    shadow_dropped = 1'b0;
                end
            end
        end
        mismatch_count  <= mismatches;
        pending_results <= sorted_results.size();
    end

endmodule

// File: tb/binary_insertion_sorter_top_tb.sv
// ----------------------------------------------------------------------------
// Binary insertion sorter testbench
// Drives sets of keyed requests through the sorter under varying idle
// patterns and a long output stall; a separate checker predicts the sorted
// output and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module binary_insertion_sorter_top_tb;
    import bis_pkg::*;

    localparam int ITEM_TARGET  = 300;
    localparam int HOLD_AFTER   = 120;     // requests sent before the long stall
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 50;
    localparam int CYCLE_LIMIT  = 400000;

    // Idle pattern of the two channels, stepped through as requests go out.
    typedef enum int {
        PH_SLOW_SEND,   // sender idles 30 of 100, receiver 62 of 100
        PH_SLOW_RECV,   // sender idles 62 of 100, receiver 30 of 100
        PH_FULL_RATE    // neither side idles
    } idle_phase_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_req_t     s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_res_t    m_data;

    int          mismatch_count;
    int          pending_results;
    int          cycle_count = 0;
    int          sent_items  = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    idle_phase_t phase       = PH_SLOW_SEND;

    binary_insertion_sorter_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sort_order_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog: end the run if the sorter stops making progress.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random back-pressure by phase, plus one long stall once
    // enough requests have gone out. During the stall the sender keeps
    // offering, so the sorter finishes its set, blocks on emit and drops
    // s_ready.
    always @(posedge aclk) begin : result_side
        logic take;
        int   idle_pct;
        case (phase)
            PH_SLOW_SEND: idle_pct = 62;
            PH_SLOW_RECV: idle_pct = 30;
            default:      idle_pct = 0;
        endcase
        if (hold_left > 0) begin
            take = 1'b0;
            hold_left--;
        end else if (!hold_done && sent_items >= HOLD_AFTER) begin
            take      = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
        end else begin
            take = ($urandom_range(0, 99) >= idle_pct);
        end
        m_ready <= take;
    end

    // Offer one request, idling first at the phase's rate, and hold it until
    // accepted. Valid stays high after acceptance so back-to-back requests
    // need no second assignment in the same step.
    task automatic send_request(input logic [KEY_BITS-1:0] key,
                                input logic [PAYLOAD_BITS-1:0] payload,
                                input logic last);
        in_req_t req;
        int      idle_pct;
        req.key     = key;
        req.payload = payload;
        req.last    = last;
        case (phase)
            PH_SLOW_SEND: idle_pct = 30;
            PH_SLOW_RECV: idle_pct = 62;
            default:      idle_pct = 0;
        endcase
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    // Send one set of random records, last flag on the final one. Narrow keys
    // crowd into a few values so equal keys test stability.
    task automatic send_set(input int count, input bit narrow);
        logic [KEY_BITS-1:0] key;
        int                  i;
        for (i = 0; i < count; i++) begin
            key = narrow ? KEY_BITS'($urandom_range(0, 8) - 4) : KEY_BITS'($urandom());
            send_request(key, PAYLOAD_BITS'($urandom()), i == count - 1);
        end
    endtask

    initial begin : stimulus
        int pick;
        int count;

        // Hold reset, then release it for good.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Key extremes, zero, minus one and duplicates in a mixed order;
        // payload extremes ride along.
        send_request(16'h7FFF, 16'h0000, 1'b0);
        send_request(16'h8000, 16'hFFFF, 1'b0);
        send_request(16'h0000, 16'h0001, 1'b0);
        send_request(16'hFFFF, 16'h8000, 1'b0);
        send_request(16'h0001, 16'h7FFF, 1'b0);
        send_request(16'hFFFF, 16'h0002, 1'b0);
        send_request(16'h7FFF, 16'h0003, 1'b0);
        send_request(16'h0000, 16'h0004, 1'b1);

        // One-record sets at both key extremes.
        send_request(16'h8000, 16'hFFFF, 1'b1);
        send_request(16'h7FFF, 16'h0000, 1'b1);

        // All keys equal: output must keep arrival order.
        send_request(16'h0005, 16'h0001, 1'b0);
        send_request(16'h0005, 16'h0002, 1'b0);
        send_request(16'h0005, 16'h0003, 1'b0);
        send_request(16'h0005, 16'h0004, 1'b1);

        // Store overflow with the dropped record as the last one, then a set
        // that fills the store exactly.
        send_set(CAPACITY + 1, 1'b0);
        send_set(CAPACITY, 1'b1);

        // Random sets: mostly short, some full, some overflowing.
        while (sent_items < ITEM_TARGET) begin
            if (sent_items >= 2 * ITEM_TARGET / 3) begin
                phase = PH_FULL_RATE;
            end else if (sent_items >= ITEM_TARGET / 3) begin
                phase = PH_SLOW_RECV;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                count = CAPACITY;
            end else if (pick == 1) begin
                count = CAPACITY + $urandom_range(1, 8);
            end else begin
                count = $urandom_range(1, 8);
            end
            send_set(count, $urandom_range(0, 3) == 0);
        end

        // Drop valid, wait for the checker to see every result, then drain.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/bis_pkg.sv
rtl/binary_insertion_sorter_top.sv
tb/sort_order_checker.sv
tb/binary_insertion_sorter_top_tb.sv
